// ===== src/orf_pkg.sv =====
// ----------------------------------------------------------------------------
// Overwriting ring FIFO package
// Shared action codes, field widths and the result descriptor.
// ----------------------------------------------------------------------------
package orf_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned FILL_W      = 6;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned MAX_RESULTS = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_DUMP  = 3'd3,
    ACT_DRAIN = 3'd4,
    ACT_GET   = 3'd5
  } action_e;

  typedef struct packed {
    logic              data_valid;
    logic [FILL_W-1:0] fill_level;
    logic              dropped_oldest;
    logic              last;
  } res_meta_t;

endpackage

// ===== src/orf_mem.sv =====
// ----------------------------------------------------------------------------
// Ring storage
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module orf_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/orf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ring FIFO sequencer
// Holds pointers and fill count, decodes requests, issues storage accesses
// and walks dump, drain and get one element per cycle while the result queue has space.
// ----------------------------------------------------------------------------
module orf_ctrl #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  orf_pkg::action_e             action_i,
  input  logic [orf_pkg::DATA_W-1:0]   data_i,
  input  logic [orf_pkg::CNT_W-1:0]    count_i,
  input  logic                         space_i,
  output logic                         res_vld_o,
  output orf_pkg::res_meta_t           res_meta_o,
  output logic                         rd_en_o,
  output logic [$clog2(DEPTH)-1:0]     rd_addr_o,
  output logic                         wr_en_o,
  output logic [$clog2(DEPTH)-1:0]     wr_addr_o,
  output logic [WIDTH-1:0]             wr_data_o
);

  import orf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = ((CW > CNT_W) ? CW : CNT_W) + 1;
  localparam int unsigned RW = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e          state_q, state_d;
  action_e         mode_q, mode_d;
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]   cur_q, cur_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [RW-1:0]   rem_q, rem_d;

  logic            accept;
  logic            is_full;
  logic [KW-1:0]   len_w;
  logic [KW-1:0]   cnt_w;
  logic [KW-1:0]   diff_w;
  logic [KW-1:0]   sum_w;
  logic [KW-1:0]   lim_w;
  logic [KW-1:0]   get_w;

  function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign is_full = (fill_q == CW'(DEPTH));
  assign len_w   = KW'(fill_q);
  assign cnt_w   = KW'(count_i);
  assign diff_w  = len_w - cnt_w;
  assign lim_w   = KW'(MAX_RESULTS);
  assign get_w   = (cnt_w < len_w) ? cnt_w : len_w;

  always_comb begin
    sum_w = KW'(rd_ptr_q) + cnt_w;
    if (sum_w >= KW'(DEPTH)) begin
      sum_w = sum_w - KW'(DEPTH);
    end
  end

  assign s_ready_o = (state_q == ST_IDLE) && space_i;
  assign accept    = s_valid_i && s_ready_o;
  assign wr_addr_o = wr_ptr_q;
  assign wr_data_o = WIDTH'(data_i);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    cur_d      = cur_q;
    fill_d     = fill_q;
    rem_d      = rem_q;
    res_vld_o  = 1'b0;
    res_meta_o = '0;
    rd_en_o    = 1'b0;
    rd_addr_o  = rd_ptr_q;
    wr_en_o    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_vld_o            = 1'b1;
          res_meta_o.last      = 1'b1;
          res_meta_o.fill_level = FILL_W'(fill_q);
          unique case (action_i)
            ACT_PUSH: begin
              wr_en_o  = 1'b1;
              wr_ptr_d = inc_ptr(wr_ptr_q);
              if (is_full) begin
                rd_ptr_d                  = inc_ptr(rd_ptr_q);
                res_meta_o.dropped_oldest = 1'b1;
              end else begin
                fill_d = fill_q + 1'b1;
              end
              res_meta_o.fill_level = FILL_W'(fill_d);
            end
            ACT_POP: begin
              if (fill_q != '0) begin
                rd_en_o               = 1'b1;
                rd_ptr_d              = inc_ptr(rd_ptr_q);
                fill_d                = fill_q - 1'b1;
                res_meta_o.data_valid = 1'b1;
                res_meta_o.fill_level = FILL_W'(fill_d);
              end
            end
            ACT_PEEK: begin
              if (fill_q != '0) begin
                rd_en_o               = 1'b1;
                res_meta_o.data_valid = 1'b1;
              end
            end
            ACT_DUMP: begin
              if (len_w > cnt_w) begin
                res_vld_o = 1'b0;
                cur_d     = sum_w[PW-1:0];
                rem_d     = RW'((diff_w > lim_w) ? lim_w : diff_w);
                mode_d    = ACT_DUMP;
                state_d   = ST_RUN;
              end
            end
            ACT_DRAIN: begin
              if (fill_q == '0) begin
                rd_ptr_d = '0;
                wr_ptr_d = '0;
              end else begin
                res_vld_o = 1'b0;
                rem_d     = RW'((len_w > lim_w) ? lim_w : len_w);
                mode_d    = ACT_DRAIN;
                state_d   = ST_RUN;
              end
            end
            ACT_GET: begin
              if ((count_i != '0) && (fill_q != '0)) begin
                res_vld_o = 1'b0;
                rem_d     = RW'((get_w > lim_w) ? lim_w : get_w);
                mode_d    = ACT_GET;
                state_d   = ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (space_i) begin
          res_vld_o             = 1'b1;
          rd_en_o               = 1'b1;
          res_meta_o.data_valid = 1'b1;
          res_meta_o.last       = (rem_q == RW'(1));
          rem_d                 = rem_q - 1'b1;
          if (rem_q == RW'(1)) begin
            state_d = ST_IDLE;
          end
          unique case (mode_q)
            ACT_DUMP: begin
              rd_addr_o             = cur_q;
              cur_d                 = inc_ptr(cur_q);
              res_meta_o.fill_level = FILL_W'(fill_q);
            end
            ACT_DRAIN: begin
              if (rem_q == RW'(1)) begin
                rd_ptr_d = '0;
                wr_ptr_d = '0;
                fill_d   = '0;
              end else begin
                rd_ptr_d = inc_ptr(rd_ptr_q);
                fill_d   = fill_q - 1'b1;
              end
              res_meta_o.fill_level = FILL_W'(fill_d);
            end
            default: begin
              rd_ptr_d              = inc_ptr(rd_ptr_q);
              fill_d                = fill_q - 1'b1;
              res_meta_o.fill_level = FILL_W'(fill_d);
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= ACT_DUMP;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cur_q    <= '0;
      fill_q   <= '0;
      rem_q    <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cur_q    <= cur_d;
      fill_q   <= fill_d;
      rem_q    <= rem_d;
    end
  end

endmodule

// ===== src/orf_outq.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Aligns result descriptors with storage read data and buffers two results
// ahead of the output channel.
// ----------------------------------------------------------------------------
module orf_outq #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       res_vld_i,
  input  orf_pkg::res_meta_t         res_meta_i,
  input  logic [WIDTH-1:0]           rd_data_i,
  output logic                       space_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [orf_pkg::DATA_W-1:0] m_data_o,
  output orf_pkg::res_meta_t         m_meta_o
);

  import orf_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    res_meta_t         meta;
  } item_t;

  logic        st_vld_q;
  res_meta_t   st_meta_q;
  item_t       ent_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;
  item_t       push_item;
  item_t       head;

  assign pop     = m_valid_o && m_ready_i;
  assign space_o = (3'(cnt_q) + 3'(st_vld_q)) < (3'd2 + 3'(pop));

  assign push_item.data = st_meta_q.data_valid ? DATA_W'(rd_data_i) : '0;
  assign push_item.meta = st_meta_q;

  assign head      = ent_q[rd_ptr_q];
  assign m_valid_o = (cnt_q != 2'd0);
  assign m_data_o  = head.data;
  assign m_meta_o  = head.meta;

  always_comb begin
    cnt_d = cnt_q;
    if (st_vld_q && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!st_vld_q && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      st_vld_q <= res_vld_i;
      cnt_q    <= cnt_d;
      if (st_vld_q) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_meta_q <= res_meta_i;
    if (st_vld_q) begin
      ent_q[wr_ptr_q] <= push_item;
    end
  end

endmodule

// ===== src/overwriting_ring_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// Overwriting ring FIFO
// Circular FIFO whose push drops the oldest element when full, with pop,
// peek, dump, drain and get requests.
// ----------------------------------------------------------------------------
// Push, pop and peek are taken one request per cycle while the result queue
// has space, each giving one result. Dump, drain and get decode first, then
// give one result per cycle on the same terms, at most 32 per request; the
// rate is set by the single read port of the storage memory, read once per
// element. A two-entry result queue keeps the stream going while the output
// stalls. Storage holds no reset value; only written entries are ever read.
module overwriting_ring_fifo_unit #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // data_in[31:0], count[37:32], zero pad
  input  logic [2:0]  s_axis_tuser,  // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // data_out[31:0], fill_level[37:32],
                                     // dropped_oldest[38], zero pad
  output logic [0:0]  m_axis_tuser,  // data_valid[0]
  output logic        m_axis_tlast
);

  import orf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  logic              space;
  logic              res_vld;
  res_meta_t         res_meta;
  logic              rd_en;
  logic [PW-1:0]     rd_addr;
  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [WIDTH-1:0]  wr_data;
  logic [WIDTH-1:0]  rd_data;
  logic [DATA_W-1:0] out_data;
  res_meta_t         out_meta;

  orf_ctrl #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .action_i   (action_e'(s_axis_tuser)),
    .data_i     (s_axis_tdata[DATA_W-1:0]),
    .count_i    (s_axis_tdata[DATA_W+CNT_W-1:DATA_W]),
    .space_i    (space),
    .res_vld_o  (res_vld),
    .res_meta_o (res_meta),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  orf_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  orf_outq #(
    .WIDTH (WIDTH)
  ) u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_vld_i  (res_vld),
    .res_meta_i (res_meta),
    .rd_data_i  (rd_data),
    .space_o    (space),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (out_data),
    .m_meta_o   (out_meta)
  );

  assign m_axis_tdata = {1'b0, out_meta.dropped_oldest, out_meta.fill_level, out_data};
  assign m_axis_tuser = out_meta.data_valid;
  assign m_axis_tlast = out_meta.last;

endmodule

// ===== src/orf_checker.sv =====
// ----------------------------------------------------------------------------
// Ring FIFO port checker
// Watches the result channel for stall stability and result consistency.
// ----------------------------------------------------------------------------
module orf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0 && m_axis_tlast)
    else $error("result without element carries data or is not final");

  a_drop_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[38] |-> !m_axis_tuser[0] && m_axis_tlast)
    else $error("drop flag on a result other than a push");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[39])
    else $error("pad bit set");

endmodule

bind overwriting_ring_fifo_unit orf_checker u_orf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Overwriting ring FIFO testbench
// Drives push, pop, peek, dump, drain and get requests into the FIFO unit,
// mirrors its ring storage in a scoreboard and checks every result field by
// field, oldest expectation first, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  import orf_pkg::*;

  localparam int unsigned DEPTH       = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_ITEMS  = 190;

  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic [FILL_W-1:0] fill_level;
    logic              dropped;
    logic              last;
  } fifo_result_t;

  class ring_scoreboard;
    logic [DATA_W-1:0] slots [DEPTH];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    bit                full;
    fifo_result_t      expected_q [$];
    int                errors;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      full   = 1'b0;
      errors = 0;
    endfunction

    function int unsigned level();
      if (wr_ptr == rd_ptr) return full ? DEPTH : 0;
      return (wr_ptr > rd_ptr) ? wr_ptr - rd_ptr : DEPTH - rd_ptr + wr_ptr;
    endfunction

    function int unsigned advance(int unsigned p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function void queue_result(logic [DATA_W-1:0] d, logic v, logic dr, logic l);
      fifo_result_t r;
      r.data_out   = d;
      r.data_valid = v;
      r.fill_level = FILL_W'(level());
      r.dropped    = dr;
      r.last       = l;
      expected_q.push_back(r);
    endfunction

    function logic [DATA_W-1:0] take_oldest();
      logic [DATA_W-1:0] v;
      v      = slots[rd_ptr];
      rd_ptr = advance(rd_ptr);
      full   = 1'b0;
      return v;
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [DATA_W-1:0] din,
                               logic [CNT_W-1:0] cnt);
      int unsigned       len;
      int unsigned       left;
      int unsigned       i;
      int unsigned       n;
      logic [DATA_W-1:0] v;
      logic              dr;
      len = level();
      n   = 0;
      case (act)
        ACT_PUSH: begin
          dr = full;
          slots[wr_ptr] = din;
          if (full) rd_ptr = advance(rd_ptr);
          wr_ptr = advance(wr_ptr);
          full   = (wr_ptr == rd_ptr);
          queue_result('0, 1'b0, dr, 1'b1);
        end
        ACT_POP, ACT_PEEK: begin
          if (len == 0) begin
            queue_result('0, 1'b0, 1'b0, 1'b1);
          end else if (act == ACT_POP) begin
            v = take_oldest();
            queue_result(v, 1'b1, 1'b0, 1'b1);
          end else begin
            queue_result(slots[rd_ptr], 1'b1, 1'b0, 1'b1);
          end
        end
        ACT_DUMP: begin
          if (len <= cnt) begin
            queue_result('0, 1'b0, 1'b0, 1'b1);
          end else begin
            for (i = 32'(cnt); i < len && n < MAX_RESULTS; i++) begin
              queue_result(slots[(rd_ptr + i) % DEPTH], 1'b1, 1'b0,
                           (i == len - 1) || (n == MAX_RESULTS - 1));
              n++;
            end
          end
        end
        ACT_DRAIN: begin
          if (len == 0) queue_result('0, 1'b0, 1'b0, 1'b1);
          while (level() > 0 && n < MAX_RESULTS) begin
            v = take_oldest();
            if (level() == 0 || n == MAX_RESULTS - 1) begin
              wr_ptr = 0;
              rd_ptr = 0;
              full   = 1'b0;
            end
            queue_result(v, 1'b1, 1'b0, level() == 0);
            n++;
          end
          wr_ptr = 0;
          rd_ptr = 0;
          full   = 1'b0;
        end
        ACT_GET: begin
          if (cnt == 0 || len == 0) begin
            queue_result('0, 1'b0, 1'b0, 1'b1);
          end else begin
            left = 32'(cnt);
            while (left > 0 && level() > 0 && n < MAX_RESULTS) begin
              v = take_oldest();
              left--;
              n++;
              queue_result(v, 1'b1, 1'b0,
                           (left == 0) || (level() == 0) || (n == MAX_RESULTS));
            end
          end
        end
        default: queue_result('0, 1'b0, 1'b0, 1'b1);
      endcase
    endfunction

    function void compare_field(string label, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [39:0] tdata, logic [0:0] tuser, logic tlast);
      fifo_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got tdata %h tuser %b tlast %b",
                 $time, tdata, tuser, tlast);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("data_out", e.data_out, tdata[31:0]);
      compare_field("fill_level", DATA_W'(e.fill_level), DATA_W'(tdata[37:32]));
      compare_field("dropped_oldest", DATA_W'(e.dropped), DATA_W'(tdata[38]));
      compare_field("tdata pad", '0, DATA_W'(tdata[39]));
      compare_field("data_valid", DATA_W'(e.data_valid), DATA_W'(tuser[0]));
      compare_field("last", DATA_W'(e.last), DATA_W'(tlast));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  ring_scoreboard sb = new();
  int unsigned    items_sent = 0;
  int unsigned    rx_hold_cycles = 0;
  bit             tx_calm = 1'b0;
  bit             rx_calm = 1'b0;

  overwriting_ring_fifo_unit #(
    .DEPTH(DEPTH),
    .WIDTH(DATA_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(logic [ACT_W-1:0] act, logic [DATA_W-1:0] din,
                              logic [CNT_W-1:0] cnt);
    int unsigned gap;
    bit          accepted;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, cnt, din};
    s_axis_tuser  <= act;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk_i);
      accepted = s_axis_tready;
      @(posedge clk_i);
    end
    sb.note_request(act, din, cnt);
    items_sent++;
  endtask

  task automatic push_burst(int unsigned n);
    repeat (n) send_request(ACT_PUSH, $urandom, CNT_W'($urandom_range(0, 63)));
  endtask

  task automatic rand_request();
    int unsigned       r;
    int unsigned       len;
    logic [DATA_W-1:0] din;
    logic [CNT_W-1:0]  cnt;
    logic [ACT_W-1:0]  act;
    r   = $urandom_range(0, 99);
    len = sb.level();
    din = $urandom;
    case ($urandom_range(0, 15))
      0: din = '0;
      1: din = '1;
      default: ;
    endcase
    cnt = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 63))
                                      : CNT_W'($urandom_range(0, len));
    if (r < 35)      act = ACT_PUSH;
    else if (r < 50) act = ACT_POP;
    else if (r < 58) act = ACT_PEEK;
    else if (r < 70) act = ACT_DUMP;
    else if (r < 85) act = ACT_GET;
    else if (r < 93) act = ACT_DRAIN;
    else             act = r[0] ? ACT_SPARE6 : ACT_SPARE7;
    send_request(act, din, cnt);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random back-pressure plus the long hold requested by the stimulus
  initial begin
    int unsigned stall;
    int unsigned span;
    stall = 0;
    span  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
        span    = $urandom_range(20, 80);
      end
      span--;
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap(rx_calm);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int unsigned rand_goal;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty FIFO and unused actions
    send_request(ACT_POP, '0, '0);
    send_request(ACT_PEEK, '0, '0);
    send_request(ACT_GET, '0, 6'd0);
    send_request(ACT_GET, '0, 6'd5);
    send_request(ACT_DUMP, '0, 6'd0);
    send_request(ACT_DRAIN, '0, '0);
    send_request(ACT_SPARE6, '1, '1);
    send_request(ACT_SPARE7, '0, '0);
    // data extremes, skips at and beyond the fill level
    send_request(ACT_PUSH, '0, '0);
    send_request(ACT_PUSH, '1, '0);
    send_request(ACT_PUSH, 32'ha5a5_5a5a, '1);
    send_request(ACT_PEEK, '0, '0);
    send_request(ACT_DUMP, '0, 6'd0);
    send_request(ACT_DUMP, '0, 6'd3);
    send_request(ACT_DUMP, '0, '1);
    send_request(ACT_GET, '0, 6'd0);
    send_request(ACT_GET, '0, 6'd2);
    send_request(ACT_POP, '0, '0);
    send_request(ACT_POP, '0, '0);
    send_request(ACT_PUSH, 32'h0000_0001, 6'd32);
    send_request(ACT_DRAIN, '0, '0);
    send_request(ACT_SPARE6, '0, '0);
    wait_drained();

    // hold the output while the input keeps pushing, then overwrite on full
    rx_hold_cycles = 300;
    push_burst(40);

    rand_goal = items_sent + RAND_ITEMS;
    while (items_sent < rand_goal) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: push_burst($urandom_range(20, 40));
        8: begin
          repeat ($urandom_range(1, 4)) rand_request();
          send_request(ACT_DRAIN, $urandom, CNT_W'($urandom_range(0, 63)));
        end
        9: begin
          wait_drained();
          repeat (12) rand_request();
        end
        default: repeat (12) rand_request();
      endcase
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
